// File: src/tgr_pkg.sv
// shared types, constants and codes for the touch gesture recognizer
package tgr_pkg;

	localparam int COORD_BITS    = 12;
	localparam int TIME_BITS     = 32;
	localparam int THR_BITS      = 12;
	localparam int TOUT_BITS     = 16;
	localparam int MOVE_BITS     = 12;
	localparam int GAP_BITS      = 16;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	localparam int IN_BITS       = TIME_BITS + 2 * COORD_BITS + 2;
	localparam int IN_BYTES_BITS = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS      = 4 + 4 * COORD_BITS;
	localparam int OUT_BYTES_BITS = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SWIPE_THRESHOLD = 2'd0,
		REG_TAP_TIMEOUT     = 2'd1,
		REG_TAP_MAX_MOVE    = 2'd2,
		REG_DOUBLE_TAP_GAP  = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		GEST_NONE        = 4'd0,
		GEST_TAP         = 4'd1,
		GEST_DOUBLE_TAP  = 4'd2,
		GEST_ONE_LEFT    = 4'd3,
		GEST_ONE_RIGHT   = 4'd4,
		GEST_ONE_UP      = 4'd5,
		GEST_ONE_DOWN    = 4'd6,
		GEST_TWO_LEFT    = 4'd7,
		GEST_TWO_RIGHT   = 4'd8,
		GEST_TWO_UP      = 4'd9,
		GEST_TWO_DOWN    = 4'd10
	} gesture_t;

	// touch sample, last field in the lowest bits
	typedef struct packed {
		logic                  second_present;
		logic [COORD_BITS-1:0] first_y;
		logic [COORD_BITS-1:0] first_x;
		logic                  first_present;
		logic [TIME_BITS-1:0]  time_ms;
	} sample_t;

	// classification result, last field in the lowest bits
	typedef struct packed {
		logic [COORD_BITS-1:0] end_y;
		logic [COORD_BITS-1:0] end_x;
		logic [COORD_BITS-1:0] start_y;
		logic [COORD_BITS-1:0] start_x;
		gesture_t              gesture;
	} result_t;

	// configuration write request
	typedef struct packed {
		logic                     we;
		cfg_reg_t                 index;
		logic [CFG_DATA_BITS-1:0] data;
	} cfg_wr_t;

endpackage

// File: src/touch_gesture_recognizer.sv
// Touch gesture recognizer: input register, classification core, output register.
// An accepted sample word passes the input register, then the output register, to m_tdata.
// Throughput: one sample word per cycle; only an output stall holds the input register.
// Each sample word yields exactly one result word, in order.
// Reset (arst_n low) clears tracking state and both valid flags and loads
// the default thresholds: swipe 50, tap timeout 200, tap move 10, double tap gap 300.
module touch_gesture_recognizer
	import tgr_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration write port
	input  logic                      cfg_we,
	input  logic [CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	// sample words
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// time_ms, first_present, first_x, first_y, second_present, zero fill
	input  logic [IN_BYTES_BITS-1:0]  s_tdata,
	// result words
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// gesture, start_x, start_y, end_x, end_y, zero fill
	output logic [OUT_BYTES_BITS-1:0] m_tdata
);

	logic    in_valid_s1;
	sample_t sample_s1;
	logic    out_valid_q;
	result_t result_q;
	result_t result_d;
	cfg_wr_t cfg;
	logic    out_free;
	logic    advance;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = in_valid_s1 && out_free;
	assign s_tready = !in_valid_s1 || out_free;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_reg_t'(cfg_index);
	assign cfg.data  = cfg_data;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			sample_s1 <= sample_t'(s_tdata[IN_BITS-1:0]);
	end

	tgr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.sample (sample_s1),
		.result (result_d)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= in_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_q <= result_d;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_BYTES_BITS'(result_q);

	// input side stalls only behind a full, stalled output register
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled while output register could move");

	// a held sample is not dropped while the output is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && !out_free) |=> in_valid_s1)
		else $error("pending sample lost during output stall");

	// gesture code stays within the defined set
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3:0] <= GEST_TWO_DOWN))
		else $error("gesture code out of range");

endmodule

// File: src/tgr_core.sv
// touch tracking state, configuration registers and gesture classification
module tgr_core
	import tgr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_wr_t cfg,
	input  logic    step,
	input  sample_t sample,
	output result_t result
);

	localparam int MAG_W = (COORD_BITS > THR_BITS) ?
		((COORD_BITS > MOVE_BITS) ? COORD_BITS : MOVE_BITS) :
		((THR_BITS > MOVE_BITS) ? THR_BITS : MOVE_BITS);

	logic [THR_BITS-1:0]   swipe_threshold_q;
	logic [TOUT_BITS-1:0]  tap_timeout_q;
	logic [MOVE_BITS-1:0]  tap_max_move_q;
	logic [GAP_BITS-1:0]   double_tap_gap_q;

	logic                  tracking_q, tracking_d;
	logic                  two_fingers_q, two_fingers_d;
	logic [TIME_BITS-1:0]  start_time_q, start_time_d;
	logic [TIME_BITS-1:0]  last_tap_q, last_tap_d;
	logic [COORD_BITS-1:0] origin_x_q, origin_x_d, origin_y_q, origin_y_d;
	logic [COORD_BITS-1:0] latest_x_q, latest_x_d, latest_y_q, latest_y_d;

	logic signed [COORD_BITS:0] dx, dy;
	logic [COORD_BITS-1:0]      abs_dx, abs_dy;
	logic [MAG_W-1:0]           mag_dx, mag_dy, thr_w, move_w;
	logic [TIME_BITS-1:0]       duration, tap_gap;
	logic                       release_touch, is_tap;
	gesture_t                   gesture_d, swipe_gesture;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swipe_threshold_q <= THR_BITS'(50);
			tap_timeout_q     <= TOUT_BITS'(200);
			tap_max_move_q    <= MOVE_BITS'(10);
			double_tap_gap_q  <= GAP_BITS'(300);
		end else if (cfg.we) begin
			unique case (cfg.index)
				REG_SWIPE_THRESHOLD: swipe_threshold_q <= cfg.data[THR_BITS-1:0];
				REG_TAP_TIMEOUT:     tap_timeout_q     <= cfg.data[TOUT_BITS-1:0];
				REG_TAP_MAX_MOVE:    tap_max_move_q    <= cfg.data[MOVE_BITS-1:0];
				REG_DOUBLE_TAP_GAP:  double_tap_gap_q  <= cfg.data[GAP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// movement, duration and tap gap of the current touch
	always_comb begin
		dx       = $signed({1'b0, latest_x_q}) - $signed({1'b0, origin_x_q});
		dy       = $signed({1'b0, latest_y_q}) - $signed({1'b0, origin_y_q});
		abs_dx   = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
		abs_dy   = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
		mag_dx   = MAG_W'(abs_dx);
		mag_dy   = MAG_W'(abs_dy);
		thr_w    = MAG_W'(swipe_threshold_q);
		move_w   = MAG_W'(tap_max_move_q);
		duration = sample.time_ms - start_time_q;
		tap_gap  = sample.time_ms - last_tap_q;
		is_tap   = (duration < TIME_BITS'(tap_timeout_q)) &&
			(mag_dx < move_w) && (mag_dy < move_w);
	end

	// swipe along the dominant axis, vertical wins a tie
	always_comb begin
		swipe_gesture = GEST_NONE;
		if (mag_dx > mag_dy) begin
			if (mag_dx >= thr_w) begin
				if (!dx[COORD_BITS] && (dx != '0))
					swipe_gesture = two_fingers_q ? GEST_TWO_RIGHT : GEST_ONE_RIGHT;
				else
					swipe_gesture = two_fingers_q ? GEST_TWO_LEFT : GEST_ONE_LEFT;
			end
		end else begin
			if (mag_dy >= thr_w) begin
				if (!dy[COORD_BITS] && (dy != '0))
					swipe_gesture = two_fingers_q ? GEST_TWO_DOWN : GEST_ONE_DOWN;
				else
					swipe_gesture = two_fingers_q ? GEST_TWO_UP : GEST_ONE_UP;
			end
		end
	end

	// next state for one sample
	always_comb begin
		tracking_d    = tracking_q;
		two_fingers_d = two_fingers_q;
		start_time_d  = start_time_q;
		last_tap_d    = last_tap_q;
		origin_x_d    = origin_x_q;
		origin_y_d    = origin_y_q;
		latest_x_d    = latest_x_q;
		latest_y_d    = latest_y_q;
		gesture_d     = GEST_NONE;
		release_touch = 1'b0;
		if ((sample.first_present || sample.second_present) && !tracking_q) begin
			// touch start latches finger one even if only finger two landed
			start_time_d  = sample.time_ms;
			origin_x_d    = sample.first_x;
			origin_y_d    = sample.first_y;
			latest_x_d    = sample.first_x;
			latest_y_d    = sample.first_y;
			tracking_d    = 1'b1;
			two_fingers_d = sample.first_present && sample.second_present;
		end else begin
			if (tracking_q && sample.first_present && sample.second_present)
				two_fingers_d = 1'b1;
			if (sample.first_present) begin
				latest_x_d = sample.first_x;
				latest_y_d = sample.first_y;
			end
			release_touch = !sample.first_present && !sample.second_present && tracking_q;
			if (release_touch) begin
				tracking_d = 1'b0;
				if (is_tap) begin
					if (tap_gap < TIME_BITS'(double_tap_gap_q)) begin
						gesture_d  = GEST_DOUBLE_TAP;
						last_tap_d = '0;
					end else begin
						gesture_d  = GEST_TAP;
						last_tap_d = sample.time_ms;
					end
				end else begin
					gesture_d = swipe_gesture;
				end
			end
		end
	end

	// tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q    <= 1'b0;
			two_fingers_q <= 1'b0;
			start_time_q  <= '0;
			last_tap_q    <= '0;
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			latest_x_q    <= '0;
			latest_y_q    <= '0;
		end else if (step) begin
			tracking_q    <= tracking_d;
			two_fingers_q <= two_fingers_d;
			start_time_q  <= start_time_d;
			last_tap_q    <= last_tap_d;
			origin_x_q    <= origin_x_d;
			origin_y_q    <= origin_y_d;
			latest_x_q    <= latest_x_d;
			latest_y_q    <= latest_y_d;
		end
	end

	// result reports the state after this sample
	always_comb begin
		result.gesture = gesture_d;
		result.start_x = origin_x_d;
		result.start_y = origin_y_d;
		result.end_x   = latest_x_d;
		result.end_y   = latest_y_d;
	end

endmodule
